// File: rtl/udpdmx_pkg.sv
// Package for the UDP port demultiplexer table: field widths, codes and
// the records passed between the front end, the queue and the back end.
// No dependencies.
package udpdmx_pkg;

   localparam int SLOTS_DEFAULT = 64;

   localparam int PORT_W   = 16;
   localparam int HID_W    = 8;
   localparam int IP_W     = 32;
   localparam int LEN_W    = 16;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] UDP_HDR_BYTES = LEN_W'(8);

   localparam logic OP_BIND    = 1'b0;
   localparam logic OP_DELIVER = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_BOUND       = 3'd0,
      ST_FULL        = 3'd1,
      ST_DELIVERED   = 3'd2,
      ST_NO_HANDLER  = 3'd3,
      ST_UNREACHABLE = 3'd4,
      ST_SHORT       = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CMD_BIND,
      CMD_FULL,
      CMD_SHORT,
      CMD_LOOKUP
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [PORT_W-1:0] port;
      logic [HID_W-1:0]  handler;
      logic [IP_W-1:0]   src_ip;
      logic [PORT_W-1:0] peer_port;
      logic [LEN_W-1:0]  payload_len;
   } work_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [HID_W-1:0]  handler;
      logic [IP_W-1:0]   src_ip;
      logic [PORT_W-1:0] peer_port;
      logic [LEN_W-1:0]  payload_len;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } occ_type;

endpackage

// File: rtl/udpdmx_req_if.sv
// Request channel: bind or deliver header fields with valid/ready.
// Depends on udpdmx_pkg.
interface udpdmx_req_if;
   import udpdmx_pkg::*;

   logic              valid;
   logic              ready;
   logic              opcode;
   logic [PORT_W-1:0] port;
   logic [HID_W-1:0]  handler_id;
   logic [IP_W-1:0]   src_ip;
   logic [PORT_W-1:0] peer_port;
   logic [LEN_W-1:0]  udp_length;

   modport source (
      output valid, opcode, port, handler_id, src_ip, peer_port, udp_length,
      input  ready
   );

   modport sink (
      input  valid, opcode, port, handler_id, src_ip, peer_port, udp_length,
      output ready
   );

endinterface

// File: rtl/udpdmx_rsp_if.sv
// Response channel: status, slot and handler delivery fields with valid/ready.
// Depends on udpdmx_pkg.
interface udpdmx_rsp_if;
   import udpdmx_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [HID_W-1:0]    handler_out;
   logic [IP_W-1:0]     src_ip_out;
   logic [PORT_W-1:0]   peer_port_out;
   logic [LEN_W-1:0]    payload_len;

   modport source (
      output valid, status, slot, handler_out, src_ip_out, peer_port_out, payload_len,
      input  ready
   );

   modport sink (
      input  valid, status, slot, handler_out, src_ip_out, peer_port_out, payload_len,
      output ready
   );

endinterface

// File: rtl/udpdmx_front.sv
// Front end: accepts requests, keeps the fill count and classifies each
// request into a queue command. Depends on udpdmx_pkg and udpdmx_req_if.
module udpdmx_front #(
   parameter  int SLOTS = udpdmx_pkg::SLOTS_DEFAULT,
   localparam int CW    = $clog2(SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   udpdmx_req_if.sink            req_ch,
   input  udpdmx_pkg::occ_type   q_stat,
   output logic                  q_push,
   output udpdmx_pkg::work_type  push_work,
   output logic [CW-1:0]         push_idx,
   output udpdmx_pkg::occ_type   tbl_stat
);
   import udpdmx_pkg::*;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          tbl_full;

   assign tbl_full       = (count_ff == CW'(SLOTS));
   assign tbl_stat.full  = tbl_full;
   assign tbl_stat.empty = (count_ff == '0);

   assign req_ch.ready = !q_stat.full;
   assign q_push       = req_ch.valid && req_ch.ready;
   assign push_idx     = count_ff;

   always_comb begin
      push_work.port        = req_ch.port;
      push_work.handler     = req_ch.handler_id;
      push_work.src_ip      = req_ch.src_ip;
      push_work.peer_port   = req_ch.peer_port;
      push_work.payload_len = req_ch.udp_length - UDP_HDR_BYTES;
      if (req_ch.opcode == OP_BIND) begin
         push_work.cmd = tbl_full ? CMD_FULL : CMD_BIND;
      end else if (req_ch.udp_length < UDP_HDR_BYTES) begin
         push_work.cmd = CMD_SHORT;
      end else begin
         push_work.cmd = CMD_LOOKUP;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (q_push && push_work.cmd == CMD_BIND) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/udpdmx_fifo.sv
// Two-entry command queue between front end and back end.
// Depends on udpdmx_pkg.
module udpdmx_fifo #(
   parameter int W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [W-1:0]        push_data,
   input  logic                pop,
   output logic [W-1:0]        pop_data,
   output udpdmx_pkg::occ_type stat
);
   import udpdmx_pkg::*;

   logic [W-1:0] entry_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   cnt_ff;
   logic [1:0]   cnt_in;
   logic         do_push;
   logic         do_pop;

   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: rtl/udpdmx_back.sv
// Back end: binding memory, slot scan for deliveries and the response register.
// Depends on udpdmx_pkg and udpdmx_rsp_if.
module udpdmx_back #(
   parameter  int SLOTS = udpdmx_pkg::SLOTS_DEFAULT,
   localparam int CW    = $clog2(SLOTS + 1),
   localparam int IW    = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  udpdmx_pkg::occ_type  q_stat,
   output logic                 q_pop,
   input  udpdmx_pkg::work_type pop_work,
   input  logic [CW-1:0]        pop_idx,
   udpdmx_rsp_if.source         rsp_ch
);
   import udpdmx_pkg::*;

   localparam int MW = PORT_W + HID_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESULT
   } state_type;

   logic [MW-1:0]     bind_mem_ff [SLOTS];
   logic [MW-1:0]     rd_data_ff;
   logic              mem_we;
   logic [IW-1:0]     mem_wa;
   logic [IW-1:0]     mem_ra;
   logic [PORT_W-1:0] rd_port;
   logic [HID_W-1:0]  rd_handler;
   logic              hit;
   logic              out_free;

   state_type  state_ff, state_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   work_type      cur_ff, cur_in;
   result_type    res_ff, res_in;
   logic          out_vld_ff, out_vld_in;
   result_type    out_ff, out_in;

   assign q_pop      = (state_ff == S_IDLE) && !q_stat.empty;
   assign mem_we     = q_pop && (pop_work.cmd == CMD_BIND);
   assign mem_wa     = pop_idx[IW-1:0];
   assign mem_ra     = scan_ff[IW-1:0];
   assign rd_port    = rd_data_ff[MW-1:HID_W];
   assign rd_handler = rd_data_ff[HID_W-1:0];
   assign hit        = cmp_vld_ff && (rd_port == cur_ff.port);
   assign out_free   = !out_vld_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bind_mem_ff[mem_wa] <= {pop_work.port, pop_work.handler};
      end
      rd_data_ff <= bind_mem_ff[mem_ra];
   end

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      limit_in   = limit_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      cur_in     = cur_ff;
      res_in     = res_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;

      if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               cur_in     = pop_work;
               limit_in   = pop_idx;
               scan_in    = '0;
               cmp_vld_in = 1'b0;
               res_in     = '0;
               case (pop_work.cmd)
                  CMD_BIND: begin
                     res_in.status = ST_BOUND;
                     res_in.slot   = SLOT_W'(pop_idx[IW-1:0]);
                     state_in      = S_RESULT;
                  end
                  CMD_FULL: begin
                     res_in.status = ST_FULL;
                     state_in      = S_RESULT;
                  end
                  CMD_SHORT: begin
                     res_in.status = ST_SHORT;
                     state_in      = S_RESULT;
                  end
                  CMD_LOOKUP: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_in      = '0;
               res_in.slot = SLOT_W'(cmp_idx_ff);
               if (rd_handler != '0) begin
                  res_in.status      = ST_DELIVERED;
                  res_in.handler     = rd_handler;
                  res_in.src_ip      = cur_ff.src_ip;
                  res_in.peer_port   = cur_ff.peer_port;
                  res_in.payload_len = cur_ff.payload_len;
               end else begin
                  res_in.status = ST_NO_HANDLER;
               end
               cmp_vld_in = 1'b0;
               state_in   = S_RESULT;
            end else if (scan_ff < limit_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else begin
               cmp_vld_in = 1'b0;
               if (!cmp_vld_ff) begin
                  res_in        = '0;
                  res_in.status = ST_UNREACHABLE;
                  state_in      = S_RESULT;
               end
            end
         end
         S_RESULT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in     = res_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
      end
      scan_ff    <= scan_in;
      limit_ff   <= limit_in;
      cmp_idx_ff <= cmp_idx_in;
      cur_ff     <= cur_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.status        = out_ff.status;
   assign rsp_ch.slot          = out_ff.slot;
   assign rsp_ch.handler_out   = out_ff.handler;
   assign rsp_ch.src_ip_out    = out_ff.src_ip;
   assign rsp_ch.peer_port_out = out_ff.peer_port;
   assign rsp_ch.payload_len   = out_ff.payload_len;

endmodule

// File: rtl/udp_port_demux_table.sv
// UDP port demultiplexer table. Bind, table-full and short-length requests are answered
// from the queue through the result register and then the response register; the back end
// takes the next request from the queue only once it has passed on the last response.
// Lookups scan the binding memory at one slot per cycle up to the fill count; a hit ends it.
// A two-entry queue lets the front end keep taking requests during a scan.
// Synchronous reset empties the table (fill count to zero) and the queue; no clearing pass.
module udp_port_demux_table #(
   parameter int SLOTS = udpdmx_pkg::SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   udpdmx_req_if.sink   req_ch,
   udpdmx_rsp_if.source rsp_ch
);
   import udpdmx_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);
   localparam int QW = $bits(work_type) + CW;

   occ_type       q_stat;
   occ_type       tbl_stat;
   logic          q_push;
   logic          q_pop;
   work_type      push_work;
   logic [CW-1:0] push_idx;
   work_type      pop_work;
   logic [CW-1:0] pop_idx;
   logic [QW-1:0] q_wdata;
   logic [QW-1:0] q_rdata;

   assign q_wdata  = {push_work, push_idx};
   assign pop_work = q_rdata[QW-1:CW];
   assign pop_idx  = q_rdata[CW-1:0];

   udpdmx_front #(.SLOTS(SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .push_work (push_work),
      .push_idx  (push_idx),
      .tbl_stat  (tbl_stat)
   );

   udpdmx_fifo #(.W(QW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   udpdmx_back #(.SLOTS(SLOTS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .pop_work (pop_work),
      .pop_idx  (pop_idx),
      .rsp_ch   (rsp_ch)
   );

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   a_bound_occupied : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_BOUND) |-> !tbl_stat.empty)
      else $error("bind response with empty table");

   a_full_consistent : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_FULL) |-> tbl_stat.full)
      else $error("table-full response while table has free slots");

endmodule

// File: verif/udp_port_demux_table_checker.sv
// Scoreboard for udp_port_demux_table: mirrors the port binding table, predicts
// one response per request transfer and compares each response transfer with it.
// Depends on udpdmx_pkg and the udpdmx_req_if / udpdmx_rsp_if interfaces.
module udp_port_demux_table_checker #(
   parameter int SLOTS = udpdmx_pkg::SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   udpdmx_req_if      req_ch,
   udpdmx_rsp_if      rsp_ch,
   output int         mismatches,
   output int         pending,
   output int         checked,
   output logic [5:0] status_seen
);
   import udpdmx_pkg::*;

   logic              slot_busy  [SLOTS];
   logic [PORT_W-1:0] slot_dport [SLOTS];
   logic [HID_W-1:0]  slot_hid   [SLOTS];
   result_type        due_rsp_q  [$];

   function automatic result_type route_request(
      input logic              op,
      input logic [PORT_W-1:0] port,
      input logic [HID_W-1:0]  hid,
      input logic [IP_W-1:0]   sip,
      input logic [PORT_W-1:0] sport,
      input logic [LEN_W-1:0]  ulen
   );
      result_type r;
      r = '0;
      if (op == OP_BIND) begin
         r.status = ST_FULL;
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i]) begin
               slot_busy[i]  = 1'b1;
               slot_dport[i] = port;
               slot_hid[i]   = hid;
               r.status      = ST_BOUND;
               r.slot        = SLOT_W'(i);
               return r;
            end
         end
         return r;
      end
      if (ulen < UDP_HDR_BYTES) begin
         r.status = ST_SHORT;
         return r;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_busy[i] && slot_dport[i] == port) begin
            r.slot = SLOT_W'(i);
            if (slot_hid[i] != '0) begin
               r.status      = ST_DELIVERED;
               r.handler     = slot_hid[i];
               r.src_ip      = sip;
               r.peer_port   = sport;
               r.payload_len = ulen - UDP_HDR_BYTES;
            end else begin
               r.status = ST_NO_HANDLER;
            end
            return r;
         end
      end
      r.status = ST_UNREACHABLE;
      return r;
   endfunction

   always @(posedge clock) begin : score
      result_type got;
      result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
         due_rsp_q.delete();
         mismatches  = 0;
         checked     = 0;
         status_seen = '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_rsp_q.push_back(route_request(req_ch.opcode, req_ch.port, req_ch.handler_id,
                                              req_ch.src_ip, req_ch.peer_port,
                                              req_ch.udp_length));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status      = status_type'(rsp_ch.status);
            got.slot        = rsp_ch.slot;
            got.handler     = rsp_ch.handler_out;
            got.src_ip      = rsp_ch.src_ip_out;
            got.peer_port   = rsp_ch.peer_port_out;
            got.payload_len = rsp_ch.payload_len;
            if (due_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response, status %0d slot %0d", $time,
                           rsp_ch.status, rsp_ch.slot);
            end else begin
               want = due_rsp_q.pop_front();
               checked++;
               status_seen[want.status] = 1'b1;
               if (got.status !== want.status || got.slot !== want.slot
                   || got.handler !== want.handler || got.src_ip !== want.src_ip
                   || got.peer_port !== want.peer_port
                   || got.payload_len !== want.payload_len) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: response mismatch", $time);
                     $display("   expected status %0d slot %0d handler %h ip %h sport %h len %h",
                              want.status, want.slot, want.handler, want.src_ip,
                              want.peer_port, want.payload_len);
                     $display("   actual   status %0d slot %0d handler %h ip %h sport %h len %h",
                              got.status, got.slot, got.handler, got.src_ip,
                              got.peer_port, got.payload_len);
                  end
               end
            end
         end
      end
      pending = due_rsp_q.size();
   end

endmodule

// File: verif/udp_port_demux_table_test.sv
// Testbench top for udp_port_demux_table: clock, reset, request stimulus and
// response back-pressure; checking is done by udp_port_demux_table_checker.
// Depends on udpdmx_pkg, the channel interfaces, the block and the checker.
module udp_port_demux_table_test;
   import udpdmx_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int         mismatches;
   int         pending;
   int         checked;
   logic [5:0] status_seen;

   int                req_count = 0;
   int                binds_sent = 0;
   bit                tx_calm = 1'b0;
   logic [PORT_W-1:0] bound_ports [$];

   udpdmx_req_if req_ch ();
   udpdmx_rsp_if rsp_ch ();

   udp_port_demux_table u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   udp_port_demux_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .pending     (pending),
      .checked     (checked),
      .status_seen (status_seen)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("udp_port_demux_table_test failed");
      $finish;
   end

   task automatic send_req(
      input logic              op,
      input logic [PORT_W-1:0] port,
      input logic [HID_W-1:0]  hid,
      input logic [IP_W-1:0]   sip,
      input logic [PORT_W-1:0] sport,
      input logic [LEN_W-1:0]  ulen
   );
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.port       <= port;
      req_ch.handler_id <= hid;
      req_ch.src_ip     <= sip;
      req_ch.peer_port  <= sport;
      req_ch.udp_length <= ulen;
      do @(posedge clock); while (!req_ch.ready);
      req_count++;
      @(negedge clock);
   endtask

   task automatic bind_port(input logic [PORT_W-1:0] port, input logic [HID_W-1:0] hid);
      bound_ports.push_back(port);
      binds_sent++;
      send_req(OP_BIND, port, hid, IP_W'($urandom), PORT_W'($urandom), LEN_W'($urandom));
   endtask

   task automatic deliver_hdr(
      input logic [PORT_W-1:0] port,
      input logic [IP_W-1:0]   sip,
      input logic [PORT_W-1:0] sport,
      input logic [LEN_W-1:0]  ulen
   );
      send_req(OP_DELIVER, port, HID_W'($urandom), sip, sport, ulen);
   endtask

   initial begin : rsp_drain
      int gap;
      int taken;
      bit rx_calm;
      taken   = 0;
      rx_calm = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         if (taken == 300 || taken == 900) gap = 400;
         else gap = rx_calm ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int                n;
      int                pick;
      int                sel;
      logic [PORT_W-1:0] port;
      logic [HID_W-1:0]  hid;
      logic [LEN_W-1:0]  ulen;

      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= OP_BIND;
      req_ch.port       <= '0;
      req_ch.handler_id <= '0;
      req_ch.src_ip     <= '0;
      req_ch.peer_port  <= '0;
      req_ch.udp_length <= '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      deliver_hdr(16'h0000, 32'h0A00_0001, 16'h1000, 16'd8);
      deliver_hdr(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
      deliver_hdr(16'h0035, 32'h0000_0000, 16'h0000, 16'd7);
      bind_port(16'hFFFF, 8'hFF);
      bind_port(16'h0000, 8'h00);
      bind_port(16'h0035, 8'h01);
      bind_port(16'h0035, 8'hAA);
      bind_port(16'h8000, 8'h80);
      deliver_hdr(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      deliver_hdr(16'h0000, 32'h0000_0000, 16'h0000, 16'd8);
      deliver_hdr(16'h0035, 32'hC0A8_0001, 16'h007B, 16'd8);
      deliver_hdr(16'h0035, 32'hC0A8_0001, 16'h007B, 16'd7);
      deliver_hdr(16'h1234, 32'h1234_5678, 16'h4321, 16'd100);
      deliver_hdr(16'h8000, 32'h8000_0001, 16'h5555, 16'h00AA);
      bind_port(16'h7FFF, 8'h7F);
      deliver_hdr(16'h7FFF, 32'h7FFF_FFFF, 16'hAAAA, 16'd9);
      bind_port(16'h0000, 8'h05);
      deliver_hdr(16'h0000, 32'h5555_5555, 16'h8000, 16'h8000);

      for (n = 0; n < 1200; n++) begin
         if (n % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
         if (n == 600) begin
            req_ch.valid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            hid = ($urandom_range(0, 9) == 0) ? '0 : HID_W'($urandom);
            if ($urandom_range(0, 3) == 0 && bound_ports.size() > 0)
               port = bound_ports[$urandom_range(0, bound_ports.size() - 1)];
            else
               port = PORT_W'($urandom);
            bind_port(port, hid);
         end else begin
            sel = $urandom_range(0, 19);
            if (sel < 2) ulen = LEN_W'($urandom_range(0, 7));
            else if (sel == 2) ulen = 16'hFFFF;
            else if (sel == 3) ulen = 16'd8;
            else ulen = LEN_W'($urandom);
            if (pick < 85 && bound_ports.size() > 0)
               port = bound_ports[$urandom_range(0, bound_ports.size() - 1)];
            else
               port = PORT_W'($urandom);
            deliver_hdr(port, IP_W'($urandom), PORT_W'($urandom), ulen);
         end
      end

      while (binds_sent < SLOTS_DEFAULT + 6) bind_port(PORT_W'($urandom), HID_W'($urandom));

      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);

      $display("run covered %0d requests (%0d binds), %0d responses checked",
               req_count, binds_sent, checked);
      $display("status codes seen (bit per code) %b, %0d mismatches", status_seen, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("udp_port_demux_table_test passed");
      end else begin
         $display("udp_port_demux_table_test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/udpdmx_pkg.sv
rtl/udpdmx_req_if.sv
rtl/udpdmx_rsp_if.sv
rtl/udpdmx_front.sv
rtl/udpdmx_fifo.sv
rtl/udpdmx_back.sv
rtl/udp_port_demux_table.sv
verif/udp_port_demux_table_checker.sv
verif/udp_port_demux_table_test.sv
